### rtl/tmsg_pkg.sv
// Shared constants, types and command codes for the text-mode scanline generator.
`timescale 1ns / 1ps

package tmsg_pkg;

    // Screen geometry
    localparam int CHARS_PER_ROW = 32;
    localparam int TEXT_ROWS     = 24;
    localparam int CELL_COUNT    = CHARS_PER_ROW * TEXT_ROWS;
    localparam int CELL_AW       = (CELL_COUNT > 1) ? $clog2(CELL_COUNT) : 1;
    localparam int COL_W         = (CHARS_PER_ROW > 1) ? $clog2(CHARS_PER_ROW) : 1;

    // Font store: 8 glyph rows of 128 glyphs
    localparam int GLYPH_COUNT   = 1024;
    localparam int GLYPH_AW      = 10;

    // Field widths
    localparam int ADDR_W        = 10;
    localparam int BYTE_W        = 8;
    localparam int CMP_W         = (CELL_AW > ADDR_W) ? CELL_AW : ADDR_W;

    // Number of scanlines covered by the text band
    localparam logic [BYTE_W-1:0] BAND_LINES = BYTE_W'(TEXT_ROWS * 8);

    // Output queue
    localparam int OUT_DEPTH     = 4;
    localparam int OUT_PW        = $clog2(OUT_DEPTH);
    localparam int OUT_CW        = $clog2(OUT_DEPTH + 1);

    typedef logic [CELL_AW-1:0] t_cell_addr;
    typedef logic [COL_W-1:0]   t_col;
    typedef logic [CMP_W-1:0]   t_cmp_addr;
    typedef logic [OUT_PW-1:0]  t_out_ptr;
    typedef logic [OUT_CW-1:0]  t_out_cnt;
    typedef logic [OUT_CW:0]    t_occ;

    // Input commands
    typedef enum logic [1:0] {
        CMD_SCAN = 2'd0,
        CMD_TEXT = 2'd1,
        CMD_FONT = 2'd2,
        CMD_BEEP = 2'd3
    } t_cmd;

    // One result transaction
    typedef struct packed {
        logic [BYTE_W-1:0] pixels;
        logic              visible;
        logic              last;
        logic [BYTE_W-1:0] beep_count;
    } t_result;

endpackage

### rtl/tmsg_ram.sv
// Generic single-write, single-read synchronous RAM with registered read data.
`timescale 1ns / 1ps

module tmsg_ram #(
    parameter int  WIDTH = 8,
    parameter int  DEPTH = 16,
    localparam int AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
    input  logic             i_clk,
    input  logic             i_we,
    input  logic [AW-1:0]    i_waddr,
    input  logic [WIDTH-1:0] i_wdata,
    input  logic [AW-1:0]    i_raddr,
    output logic [WIDTH-1:0] o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    // Write port and registered read port
    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        r_rdata <= r_mem[i_raddr];
    end

    assign o_rdata = r_rdata;

endmodule

### rtl/tmsg_out_fifo.sv
// Small result queue between the scanline pipeline and the output channel.
`timescale 1ns / 1ps

module tmsg_out_fifo (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_push,
    input  tmsg_pkg::t_result  i_data,
    output tmsg_pkg::t_out_cnt o_count,
    output logic               o_valid,
    output tmsg_pkg::t_result  o_data,
    input  logic               i_ready
);

    tmsg_pkg::t_result  r_mem [tmsg_pkg::OUT_DEPTH];
    tmsg_pkg::t_out_ptr r_wr_ptr;
    tmsg_pkg::t_out_ptr r_rd_ptr;
    tmsg_pkg::t_out_cnt r_count;
    logic               w_pop;

    assign w_pop   = o_valid && i_ready;
    assign o_valid = (r_count != '0);
    assign o_data  = r_mem[r_rd_ptr];
    assign o_count = r_count;

    // Store pushed entries
    always_ff @(posedge i_clk) begin
        if (i_push) begin
            r_mem[r_wr_ptr] <= i_data;
        end
    end

    // Advance pointers and occupancy
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= '0;
            r_rd_ptr <= '0;
            r_count  <= '0;
        end else begin
            if (i_push) begin
                r_wr_ptr <= r_wr_ptr + tmsg_pkg::t_out_ptr'(1);
            end
            if (w_pop) begin
                r_rd_ptr <= r_rd_ptr + tmsg_pkg::t_out_ptr'(1);
            end
            if (i_push && !w_pop) begin
                r_count <= r_count + tmsg_pkg::t_out_cnt'(1);
            end else if (!i_push && w_pop) begin
                r_count <= r_count - tmsg_pkg::t_out_cnt'(1);
            end
        end
    end

    // Never push into a full queue unless an entry pops in the same cycle
    a_no_overflow: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_count == tmsg_pkg::t_out_cnt'(tmsg_pkg::OUT_DEPTH)) |-> (!i_push || w_pop))
        else $error("result queue overflow");

    // Never pop an empty queue through the count
    a_count_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_count == '0) |=> (r_count == '0 || r_count == tmsg_pkg::t_out_cnt'(1)))
        else $error("result queue count jumped from empty");

    // A push without a pop raises the count by one
    a_count_track: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_push && !w_pop) |=> (r_count == $past(r_count) + tmsg_pkg::t_out_cnt'(1)))
        else $error("result queue count out of step");

endmodule

### rtl/text_mode_scanline_generator.sv
// Top level: text-mode 8x8 character generator with text and font stores in RAM.
`timescale 1ns / 1ps
//
// Input channel (i_valid/o_ready) carries one command per transaction:
//   scanline, write text cell, write font byte, or load the beep counter.
// Write commands take effect at the accepting edge and give no result; the
//   block is ready again in the next cycle.
// A scanline inside the text band gives CHARS_PER_ROW result transactions on
//   the output channel (o_valid/i_ready), one per cycle while the queue has
//   credit, the last one flagged. Each column passes the column issue, the
//   registered text RAM read and the registered font RAM read before its
//   result is queued. The block takes the next item only once the last
//   column has left the read pipeline through the two RAM read ports.
// A scanline outside the band gives one blank result.
// A 4-entry result queue decouples the output: when the receiver stalls, the
//   column sequencer pauses on credit and resumes without loss.
// Configuration channel (i_cfg_valid/o_cfg_ready) writes top_line; it is
//   always ready. Reset sets top_line to 20, clears the beep counter and
//   empties the queue; RAM contents are undefined until written.

module text_mode_scanline_generator (
    input  logic       i_clk,
    input  logic       i_rst_n,
    // Input channel
    input  logic       i_valid,
    output logic       o_ready,
    input  logic [1:0] i_cmd,
    input  logic [7:0] i_line,
    input  logic [9:0] i_address,
    input  logic [7:0] i_value,
    // Output channel
    output logic       o_valid,
    input  logic       i_ready,
    output logic [7:0] o_pixels,
    output logic       o_visible,
    output logic       o_last,
    output logic [7:0] o_beep_count,
    // Configuration channel
    input  logic       i_cfg_valid,
    output logic       o_cfg_ready,
    input  logic [7:0] i_cfg_data
);

    logic [7:0]           r_top_line;
    logic [7:0]           r_beep;
    logic [7:0]           n_beep;
    logic                 r_busy;
    tmsg_pkg::t_col       r_col;
    tmsg_pkg::t_cell_addr r_base;
    logic [2:0]           r_grow;
    logic                 r_s1_v;
    logic                 r_s1_last;
    logic                 r_s2_v;
    logic                 r_s2_last;
    logic                 r_s2_inv;

    logic                 w_accept;
    logic                 w_scan;
    logic [8:0]           w_rel;
    logic                 w_in_band;
    logic                 w_blank_push;
    logic                 w_issue;
    logic                 w_col_last;
    tmsg_pkg::t_occ       w_occ;
    tmsg_pkg::t_out_cnt   w_fifo_count;
    logic                 w_push;
    tmsg_pkg::t_result    w_push_data;
    tmsg_pkg::t_result    w_out_data;
    logic                 w_text_we;
    logic                 w_font_we;
    tmsg_pkg::t_cell_addr w_text_raddr;
    logic [7:0]           w_text_rdata;
    logic [tmsg_pkg::GLYPH_AW-1:0] w_font_raddr;
    logic [7:0]           w_font_rdata;

    // Input decode
    assign w_accept  = i_valid && o_ready;
    assign w_scan    = w_accept && (i_cmd == tmsg_pkg::CMD_SCAN);
    assign w_rel     = {1'b0, i_line} - {1'b0, r_top_line};
    assign w_in_band = !w_rel[8] && (w_rel[7:0] < tmsg_pkg::BAND_LINES);
    assign w_blank_push = w_scan && !w_in_band;

    assign w_text_we = w_accept && (i_cmd == tmsg_pkg::CMD_TEXT) &&
                       (tmsg_pkg::t_cmp_addr'(i_address) <
                        tmsg_pkg::t_cmp_addr'(tmsg_pkg::CELL_COUNT));
    assign w_font_we = w_accept && (i_cmd == tmsg_pkg::CMD_FONT);

    // Credit check: queued plus in-flight results must fit the queue
    assign w_occ   = {1'b0, w_fifo_count} + tmsg_pkg::t_occ'(r_s1_v)
                   + tmsg_pkg::t_occ'(r_s2_v);
    assign w_issue = r_busy && (w_occ < tmsg_pkg::t_occ'(tmsg_pkg::OUT_DEPTH));
    assign w_col_last = (r_col == tmsg_pkg::t_col'(tmsg_pkg::CHARS_PER_ROW - 1));

    assign o_ready     = !r_busy && !r_s1_v && !r_s2_v &&
                         (w_occ < tmsg_pkg::t_occ'(tmsg_pkg::OUT_DEPTH));
    assign o_cfg_ready = 1'b1;

    // Next beep counter value
    always_comb begin
        n_beep = r_beep;
        if (w_accept && (i_cmd == tmsg_pkg::CMD_BEEP)) begin
            n_beep = i_value;
        end else if (w_blank_push && (i_line == r_top_line - 8'd1) && (r_beep != '0)) begin
            n_beep = r_beep - 8'd1;
        end
    end

    // Text RAM: cell codes
    assign w_text_raddr = r_base + tmsg_pkg::t_cell_addr'(r_col);

    tmsg_ram #(
        .WIDTH(8),
        .DEPTH(tmsg_pkg::CELL_COUNT)
    ) u_text_ram (
        .i_clk  (i_clk),
        .i_we   (w_text_we),
        .i_waddr(tmsg_pkg::t_cell_addr'(i_address)),
        .i_wdata(i_value),
        .i_raddr(w_text_raddr),
        .o_rdata(w_text_rdata)
    );

    // Font RAM: glyph row bytes, addressed by glyph row and 7-bit code
    assign w_font_raddr = {r_grow, w_text_rdata[6:0]};

    tmsg_ram #(
        .WIDTH(8),
        .DEPTH(tmsg_pkg::GLYPH_COUNT)
    ) u_font_ram (
        .i_clk  (i_clk),
        .i_we   (w_font_we),
        .i_waddr(i_address),
        .i_wdata(i_value),
        .i_raddr(w_font_raddr),
        .o_rdata(w_font_rdata)
    );

    // Sequencer and column pipeline
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_top_line <= 8'd20;
            r_beep     <= '0;
            r_busy     <= 1'b0;
            r_col      <= '0;
            r_s1_v     <= 1'b0;
            r_s2_v     <= 1'b0;
        end else begin
            if (i_cfg_valid && o_cfg_ready) begin
                r_top_line <= i_cfg_data;
            end
            r_beep <= n_beep;
            if (w_scan && w_in_band) begin
                r_busy <= 1'b1;
                r_col  <= '0;
            end else if (w_issue) begin
                r_col <= w_col_last ? '0 : r_col + tmsg_pkg::t_col'(1);
                if (w_col_last) begin
                    r_busy <= 1'b0;
                end
            end
            r_s1_v <= w_issue;
            r_s2_v <= r_s1_v;
        end
    end

    // Per-scanline and per-column payload
    always_ff @(posedge i_clk) begin
        if (w_scan && w_in_band) begin
            r_base <= tmsg_pkg::t_cell_addr'(w_rel[7:3] * tmsg_pkg::CHARS_PER_ROW);
            r_grow <= w_rel[2:0];
        end
        r_s1_last <= w_col_last;
        r_s2_last <= r_s1_last;
        r_s2_inv  <= !w_text_rdata[7];
    end

    // Result push: blank line or finished column
    always_comb begin
        w_push_data.beep_count = r_beep;
        if (r_s2_v) begin
            w_push_data.pixels  = w_font_rdata ^ {8{r_s2_inv}};
            w_push_data.visible = 1'b1;
            w_push_data.last    = r_s2_last;
        end else begin
            w_push_data.pixels     = '0;
            w_push_data.visible    = 1'b0;
            w_push_data.last       = 1'b1;
            w_push_data.beep_count = n_beep;
        end
    end
    assign w_push = w_blank_push || r_s2_v;

    tmsg_out_fifo u_out_fifo (
        .i_clk  (i_clk),
        .i_rst_n(i_rst_n),
        .i_push (w_push),
        .i_data (w_push_data),
        .o_count(w_fifo_count),
        .o_valid(o_valid),
        .o_data (w_out_data),
        .i_ready(i_ready)
    );

    assign o_pixels     = w_out_data.pixels;
    assign o_visible    = w_out_data.visible;
    assign o_last       = w_out_data.last;
    assign o_beep_count = w_out_data.beep_count;

    // The final column leaves the pipeline only after issue has stopped
    a_last_idle: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_s2_v && r_s2_last) |-> !r_busy)
        else $error("column issue still running after last column");

    // Column counter is back at zero whenever a new item can start
    a_col_home: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_ready |-> (r_col == '0))
        else $error("column counter not rewound");

    // Beep counter moves only on an accepted transaction
    a_beep_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_rst_n && !w_accept) |=> $stable(r_beep))
        else $error("beep counter changed without a transaction");

    // Blank and column pushes never collide
    a_push_excl: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !(w_blank_push && r_s2_v))
        else $error("blank result collides with a column result");

endmodule
